/* src/assert_macros.svh */
// Assertion macros shared by the statistics block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define CHECK_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define CHECK_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* src/mfs_pkg.sv */
// Types and constants of the masked frame statistics block.
package mfs_pkg;

  localparam int SMP_W   = 24;
  localparam int CNT_W   = 17;
  localparam int SUM_W   = 40;
  localparam int SQ_W    = 64;
  localparam int PROD_W  = 80;
  localparam int MPL_W   = 40;
  localparam int DIV_W   = 33;
  localparam int CTR_W   = 7;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;

  localparam int MUL_STEPS  = 40;
  localparam int DIV_STEPS  = 80;
  localparam int SQRT_STEPS = 32;

  localparam logic [0:0] REG_MISSING = 1'b0;
  localparam logic [0:0] REG_FILL    = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sumsq;
    logic [SMP_W-1:0] mn;
    logic [SMP_W-1:0] mx;
  } snap_t;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MULA = 8'b0000_0010,
    ST_MULB = 8'b0000_0100,
    ST_DIFF = 8'b0000_1000,
    ST_DIVV = 8'b0001_0000,
    ST_DIVM = 8'b0010_0000,
    ST_SQRT = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } bstate_t;

endpackage

/* src/masked_frame_statistics.sv */
// Top level of the masked frame statistics block.
//
//  channel  direction  fields (low bit up)
//  s_*      in         tdata: sample[23:0]; tlast: frame_end
//  m_*      out        tdata: valid_count[16:0], mean[40:17], min[64:41],
//                      max[88:65], std_dev[112:89]; tuser: frame_empty
//  cfg_*    in         index 0 missing_value, 1 fill_value
//
// Samples enter at one per cycle while the queue has room; an empty frame skips
// the back-end arithmetic, other frames pass through it (two 40-step shift-add
// products, two 80-step restoring divides and a 32-step root in the back end).
// A two-entry snapshot queue lets the front keep taking samples while the back
// works; the front stalls once two finished frames wait.
// Reset is synchronous and sets accumulators, counters and config to defaults.
module masked_frame_statistics import mfs_pkg::*; #(
  parameter int MAX_CELLS   = 65536,
  parameter int SAMPLE_BITS = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [23:0]  s_tdata,   // sample
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [119:0] m_tdata,   // valid_count, mean, min, max, std_dev
  output logic         m_tuser,   // frame_empty
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [23:0]  cfg_data
);

  logic [SMP_W-1:0] missing_value, fill_value, fill_s;
  logic [QCNT_W-1:0] q_count;
  logic push, pop;
  snap_t push_data, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      missing_value <= 24'h800000;
      fill_value    <= 24'h800000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MISSING: missing_value <= cfg_data;
        REG_FILL:    fill_value    <= cfg_data;
        default: ;
      endcase
    end
  end

  mfs_front #(.MAX_CELLS(MAX_CELLS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk, .rst, .missing_value, .fill_value, .s_tvalid, .s_tready, .s_tdata,
    .s_tlast, .q_count, .push, .push_data, .fill_s
  );

  mfs_queue u_queue (
    .clk, .rst, .push, .push_data, .pop, .head, .count(q_count)
  );

  mfs_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk, .rst, .q_count, .head, .pop, .fill_s, .m_tvalid, .m_tready,
    .m_tdata, .m_tuser
  );

endmodule

/* src/mfs_front.sv */
// Front end: classify samples and accumulate frame sums.
module mfs_front import mfs_pkg::*; #(
  parameter int MAX_CELLS   = 65536,
  parameter int SAMPLE_BITS = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [SMP_W-1:0]  missing_value,
  input  logic [SMP_W-1:0]  fill_value,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [SMP_W-1:0]  s_tdata,
  input  logic              s_tlast,
  input  logic [QCNT_W-1:0] q_count,
  output logic              push,
  output snap_t             push_data,
  output logic [SMP_W-1:0]  fill_s
);

  localparam int SH = SMP_W - SAMPLE_BITS;
  localparam logic [SMP_W-1:0] SMP_MAXV = SMP_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic [SMP_W-1:0] SMP_MINV = ~SMP_MAXV;

  logic [SMP_W-1:0] s_shl, m_shl, f_shl;
  logic signed [SMP_W-1:0] s, miss;
  logic [SMP_W-1:0] mag;
  logic take, accept;

  logic [CNT_W-1:0] cnt;
  logic p_valid, p_take, p_end;
  logic signed [SMP_W-1:0] p_s;
  logic [2*SMP_W-1:0] p_sq;
  logic [CNT_W-1:0] p_cnt;

  logic signed [SUM_W-1:0] sum, sum_next;
  logic [SQ_W-1:0] sumsq, sumsq_next;
  logic signed [SMP_W-1:0] mn, mn_next, mx, mx_next;

  assign s_shl  = s_tdata << SH;
  assign m_shl  = missing_value << SH;
  assign f_shl  = fill_value << SH;
  assign s      = $signed(s_shl) >>> SH;
  assign miss   = $signed(m_shl) >>> SH;
  assign fill_s = SMP_W'($signed(f_shl) >>> SH);
  assign mag    = s[SMP_W-1] ? SMP_W'(-s) : SMP_W'(s);
  assign take   = (s != miss) && (s != $signed(fill_s)) && (cnt < CNT_W'(MAX_CELLS));

  assign s_tready = ({1'b0, q_count} + {{QCNT_W{1'b0}}, p_valid & p_end}) < (QCNT_W+1)'(QDEPTH);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      p_valid <= 1'b0;
    end else begin
      p_valid <= accept;
      if (accept) begin
        cnt <= s_tlast ? '0 : cnt + CNT_W'(take);
      end
    end
    if (accept) begin
      p_take <= take;
      p_end  <= s_tlast;
      p_s    <= s;
      p_sq   <= mag * mag;
      p_cnt  <= cnt + CNT_W'(take);
    end
  end

  always_comb begin
    sum_next   = sum;
    sumsq_next = sumsq;
    mn_next    = mn;
    mx_next    = mx;
    if (p_take) begin
      sum_next   = sum + SUM_W'(p_s);
      sumsq_next = sumsq + SQ_W'(p_sq);
      if (p_s < mn) mn_next = p_s;
      if (p_s > mx) mx_next = p_s;
    end
  end

  assign push            = p_valid && p_end;
  assign push_data.cnt   = p_cnt;
  assign push_data.sum   = sum_next;
  assign push_data.sumsq = sumsq_next;
  assign push_data.mn    = mn_next;
  assign push_data.mx    = mx_next;

  always_ff @(posedge clk) begin
    if (rst || push) begin
      sum   <= '0;
      sumsq <= '0;
      mn    <= SMP_MAXV;
      mx    <= SMP_MINV;
    end else if (p_valid) begin
      sum   <= sum_next;
      sumsq <= sumsq_next;
      mn    <= mn_next;
      mx    <= mx_next;
    end
  end

endmodule

/* src/mfs_queue.sv */
// Two-entry queue of frame snapshots between front and back.
module mfs_queue import mfs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  snap_t             push_data,
  input  logic              pop,
  output snap_t             head,
  output logic [QCNT_W-1:0] count
);

  `include "assert_macros.svh"

  snap_t mem [QDEPTH];
  logic [QPTR_W-1:0] wr, rd;

  assign head = mem[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      if (push) wr <= wr + 1'b1;
      if (pop)  rd <= rd + 1'b1;
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
    if (push) mem[wr] <= push_data;
  end

  `CHECK_NEVER(no_overflow, push && !pop && (count == QCNT_W'(QDEPTH)), "queue overflow")
  `CHECK_NEVER(no_underflow, pop && (count == '0), "queue underflow")

endmodule

/* src/mfs_back.sv */
// Back end: mean, variance and root of one frame over many cycles.
module mfs_back import mfs_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [QCNT_W-1:0] q_count,
  input  snap_t             head,
  output logic              pop,
  input  logic [SMP_W-1:0]  fill_s,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [119:0]      m_tdata,
  output logic              m_tuser
);

  `include "assert_macros.svh"

  localparam logic [SMP_W-1:0] SMP_MAXV = SMP_W'((1 << (SAMPLE_BITS - 1)) - 1);

  bstate_t st;
  logic [CTR_W-1:0] ctr;
  logic [CNT_W-1:0] cnt;
  logic sneg, emp;
  logic [SUM_W-1:0] smag;
  logic [SMP_W-1:0] mn, mx, mean, sd;
  logic [PROD_W-1:0] mcand, acc, acc_next, aval;
  logic [MPL_W-1:0] mplier;
  logic [DIV_W-1:0] dvs, rem, rem_next;
  logic [DIV_W:0] rem_sh;
  logic [PROD_W-1:0] quo, quo_next;
  logic ge;
  logic [SQ_W-1:0] x, res, bitv, trial, res_next;
  logic [SUM_W-1:0] qm;

  logic [CNT_W-1:0] o_cnt;
  logic [SMP_W-1:0] o_mean, o_mn, o_mx, o_sd;

  assign pop = (st == ST_IDLE) && (q_count != '0);

  assign acc_next = mplier[0] ? acc + mcand : acc;
  assign rem_sh   = {rem, quo[PROD_W-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign rem_next = ge ? DIV_W'(rem_sh - {1'b0, dvs}) : rem_sh[DIV_W-1:0];
  assign quo_next = {quo[PROD_W-2:0], ge};
  assign trial    = res + bitv;
  assign res_next = (x >= trial) ? (res >> 1) + bitv : res >> 1;
  assign qm       = quo_next[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && st != ST_FIN) m_tvalid <= 1'b0;
      unique case (st)
        ST_IDLE: begin
          if (pop) begin
            cnt    <= head.cnt;
            sneg   <= head.sum[SUM_W-1];
            smag   <= head.sum[SUM_W-1] ? -head.sum : head.sum;
            mn     <= head.mn;
            mx     <= head.mx;
            emp    <= (head.cnt == '0);
            mcand  <= PROD_W'(head.sumsq);
            mplier <= MPL_W'(head.cnt);
            acc    <= '0;
            ctr    <= '0;
            dvs    <= DIV_W'(head.cnt) * DIV_W'(head.cnt);
            st     <= (head.cnt == '0) ? ST_FIN : ST_MULA;
          end
        end
        ST_MULA: begin
          if (ctr == CTR_W'(MUL_STEPS - 1)) begin
            aval   <= acc_next;
            acc    <= '0;
            mcand  <= PROD_W'(smag);
            mplier <= smag;
            ctr    <= '0;
            st     <= ST_MULB;
          end else begin
            acc    <= acc_next;
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
            ctr    <= ctr + 1'b1;
          end
        end
        ST_MULB: begin
          acc <= acc_next;
          if (ctr == CTR_W'(MUL_STEPS - 1)) begin
            ctr <= '0;
            st  <= ST_DIFF;
          end else begin
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
            ctr    <= ctr + 1'b1;
          end
        end
        ST_DIFF: begin
          quo <= (aval >= acc) ? aval - acc : '0;
          rem <= '0;
          st  <= ST_DIVV;
        end
        ST_DIVV: begin
          if (ctr == CTR_W'(DIV_STEPS - 1)) begin
            x    <= quo_next[SQ_W-1:0];
            rem  <= '0;
            quo  <= PROD_W'(smag);
            dvs  <= DIV_W'(cnt);
            ctr  <= '0;
            st   <= ST_DIVM;
          end else begin
            rem <= rem_next;
            quo <= quo_next;
            ctr <= ctr + 1'b1;
          end
        end
        ST_DIVM: begin
          rem <= rem_next;
          quo <= quo_next;
          if (ctr == CTR_W'(DIV_STEPS - 1)) begin
            mean <= sneg ? SMP_W'(-qm) : SMP_W'(qm);
            res  <= '0;
            bitv <= SQ_W'(1) << (SQ_W - 2);
            ctr  <= '0;
            st   <= ST_SQRT;
          end else begin
            ctr <= ctr + 1'b1;
          end
        end
        ST_SQRT: begin
          if (x >= trial) x <= x - trial;
          res  <= res_next;
          bitv <= bitv >> 2;
          ctr  <= ctr + 1'b1;
          if (ctr == CTR_W'(SQRT_STEPS - 1)) begin
            sd <= (res_next > SQ_W'(SMP_MAXV)) ? SMP_MAXV : res_next[SMP_W-1:0];
            st <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            st       <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
    if (st == ST_FIN && (!m_tvalid || m_tready)) begin
      o_cnt   <= cnt;
      o_mean  <= emp ? fill_s : mean;
      o_mn    <= emp ? fill_s : mn;
      o_mx    <= emp ? fill_s : mx;
      o_sd    <= emp ? fill_s : sd;
      m_tuser <= emp;
    end
  end

  assign m_tdata = {7'b0, o_sd, o_mx, o_mn, o_mean, o_cnt};

  `CHECK_PROP(empty_has_no_count, (m_tvalid && m_tuser) |-> (o_cnt == '0), "empty frame with count")
  `CHECK_PROP(pop_only_idle, pop |=> (st != ST_IDLE), "snapshot taken without starting")

endmodule
